// ----- src/bspq_pkg.sv -----
// Shared types and constants for the bounded sorted priority queue.
package bspq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 16;
  localparam int KEY_WIDTH  = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // One stored entry
  typedef struct packed {
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] data;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic   ins_en;   // insert commits this cycle
    logic   rem_en;   // pop commits this cycle
    entry_t new_item; // item being inserted
  } cell_ctrl_t;

endpackage

// ----- src/bspq_cell.sv -----
// One slot of the sorted chain: compares against the new key and shifts.
module bspq_cell (
  input  logic                clk,
  input  bspq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                left_shift,
  input  bspq_pkg::entry_t    left_entry,
  input  bspq_pkg::entry_t    right_entry,
  output logic                shift,
  output bspq_pkg::entry_t    entry
);

  bspq_pkg::entry_t entry_next;

  // Slot sits at or after the insert point when empty or holding a larger key
  assign shift = !occ || (entry.key > ctrl.new_item.key);

  // Insert: take the left neighbor if it also moves, else the new item.
  // Pop: take the right neighbor.
  always_comb begin
    entry_next = entry;
    if (ctrl.ins_en && shift) begin
      entry_next = left_shift ? left_entry : ctrl.new_item;
    end else if (ctrl.rem_en) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- src/bounded_sorted_priority_queue.sv -----
// Top level: command handshake, occupancy count, cell chain and result register.
// Result: presented in the cycle after its command item is accepted.
// Throughput: one command per cycle while the result side does not stall; every
// cell compares and shifts in the same cycle, whatever the queue depth.
// Reset: synchronous; clears the entry count and the result valid. Slot contents
// are not cleared and are only read below the count.
module bounded_sorted_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [1:0]                        cmd,
  input  logic [bspq_pkg::DATA_WIDTH-1:0]   in_data,
  input  logic [bspq_pkg::KEY_WIDTH-1:0]    in_key,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [bspq_pkg::DATA_WIDTH-1:0]   out_data,
  output logic [bspq_pkg::KEY_WIDTH-1:0]    out_key,
  output logic                              out_valid,
  output logic                              dropped,
  output logic [bspq_pkg::CNT_W-1:0]        occupancy,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int D = bspq_pkg::DEPTH;

  logic [bspq_pkg::CNT_W-1:0] count, count_next;
  logic                       accept;
  logic                       full_now, empty_now;
  logic                       drop_now, pop_now;
  logic [D-1:0]               occ, shift;
  bspq_pkg::entry_t           entries [D];
  bspq_pkg::cell_ctrl_t       ctrl;

  // Handshake: the result register frees up as soon as it is taken
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign full_now  = (count == bspq_pkg::CNT_W'(D));
  assign empty_now = (count == '0);

  // Insert on full drops unless the last slot holds a strictly larger key
  assign drop_now = (cmd == bspq_pkg::CMD_INSERT) && full_now && !shift[D-1];
  assign pop_now  = (cmd == bspq_pkg::CMD_REMOVE) && !empty_now;

  assign ctrl.ins_en   = accept && (cmd == bspq_pkg::CMD_INSERT) && !drop_now;
  assign ctrl.rem_en   = accept && pop_now;
  assign ctrl.new_item = '{key: in_key, data: in_data};

  // Cell chain
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign occ[i] = (count > bspq_pkg::CNT_W'(i));
    bspq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .left_shift  ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1]),
      .left_entry  (entries[(i == 0) ? 0 : i - 1]),
      .right_entry (entries[(i == D - 1) ? D - 1 : i + 1]),
      .shift       (shift[i]),
      .entry       (entries[i])
    );
  end

  // Next count
  always_comb begin
    count_next = count;
    case (cmd)
      bspq_pkg::CMD_INSERT: begin
        if (!full_now) count_next = count + 1'b1;
      end
      bspq_pkg::CMD_REMOVE: begin
        if (!empty_now) count_next = count - 1'b1;
      end
      bspq_pkg::CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data  <= pop_now ? entries[0].data : '0;
      out_key   <= pop_now ? entries[0].key : '0;
      out_valid <= pop_now;
      dropped   <= drop_now;
      occupancy <= count_next;
      is_empty  <= (count_next == '0);
      is_full   <= (count_next == bspq_pkg::CNT_W'(D));
    end
  end

endmodule

// ----- src/bspq_checker.sv -----
// Port-level checker for the priority queue, bound to the top level.
module bspq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_stall,
  input logic                              rsp_valid,
  input logic                              rsp_stall,
  input logic [bspq_pkg::DATA_WIDTH-1:0]   out_data,
  input logic [bspq_pkg::KEY_WIDTH-1:0]    out_key,
  input logic                              out_valid,
  input logic                              dropped,
  input logic [bspq_pkg::CNT_W-1:0]        occupancy,
  input logic                              is_empty,
  input logic                              is_full
);

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(out_data) && $stable(out_key)
      && $stable(occupancy))
    else $error("stalled result changed");

  // Flags agree with occupancy
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (occupancy == '0))
      && (is_full == (occupancy == bspq_pkg::CNT_W'(bspq_pkg::DEPTH))))
    else $error("empty/full flags disagree with occupancy");

  // A drop only happens on a full queue, never together with a pop
  a_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dropped |-> is_full && !out_valid)
    else $error("drop reported on non-full queue or with a pop");

  // No pop data without a popped entry
  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_valid |-> (out_data == '0) && (out_key == '0))
    else $error("nonzero data without a popped entry");

  // Input is only held off while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> rsp_valid && rsp_stall)
    else $error("command stalled with no waiting result");

endmodule

bind bounded_sorted_priority_queue bspq_checker u_bspq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .out_data  (out_data),
  .out_key   (out_key),
  .out_valid (out_valid),
  .dropped   (dropped),
  .occupancy (occupancy),
  .is_empty  (is_empty),
  .is_full   (is_full)
);

// ----- tb/sv/bounded_sorted_priority_queue_test.sv -----
// Self-checking testbench for the bounded sorted priority queue.
module bounded_sorted_priority_queue_test;
  import bspq_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         DIRECTED_N   = 25;
  localparam int         RANDOM_ITEMS = 1000;
  localparam int         MAX_CYCLES   = 400000;

  // One result item as the block reports it
  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [KEY_WIDTH-1:0]  key;
    logic                  valid;
    logic                  dropped;
    logic [CNT_W-1:0]      occ;
    logic                  empty;
    logic                  full;
  } result_t;

  // One command item, with an optional hand-written expectation
  typedef struct packed {
    logic [1:0]            op;
    logic [DATA_WIDTH-1:0] data;
    logic [KEY_WIDTH-1:0]  key;
    logic                  typed;
    result_t               want;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  logic [1:0]            cmd = CMD_INSERT;
  logic [DATA_WIDTH-1:0] in_data = '0;
  logic [KEY_WIDTH-1:0]  in_key = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [DATA_WIDTH-1:0] out_data;
  logic [KEY_WIDTH-1:0]  out_key;
  logic                  out_valid;
  logic                  dropped;
  logic [CNT_W-1:0]      occupancy;
  logic                  is_empty;
  logic                  is_full;

  cmd_row_t directed [DIRECTED_N];
  cmd_row_t stim [$];
  entry_t   held [$];      // model of the sorted slots, head first
  result_t  pending [$];   // results still owed by the block
  cmd_row_t on_bus;
  result_t  want_r;
  result_t  got_r;
  int       next_idx = 0;
  int       sent = 0;
  int       cmd_gap = 0;
  int       stall_left = 0;
  int       errors = 0;
  int       cycles = 0;
  bit       calm = 1'b0;   // stretch with no idling on either side

  bounded_sorted_priority_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .in_data   (in_data),
    .in_key    (in_key),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_data  (out_data),
    .out_key   (out_key),
    .out_valid (out_valid),
    .dropped   (dropped),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  always #5 clk = ~clk;

  // Apply one command to the slot model and return the result it gives
  function automatic result_t queue_apply(logic [1:0] op, logic [DATA_WIDTH-1:0] data,
                                          logic [KEY_WIDTH-1:0] key);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    e.key = key;
    e.data = data;
    pos = 0;
    // new entry goes after every entry with key <= new key (FIFO among ties)
    while (pos < held.size() && held[pos].key <= key) pos++;
    case (op)
      CMD_INSERT: begin
        if (held.size() >= DEPTH && held[DEPTH-1].key <= key) begin
          r.dropped = 1'b1;
        end else begin
          // full: evict the tail, which holds the largest key
          if (held.size() >= DEPTH) void'(held.pop_back());
          held.insert(pos, e);
        end
      end
      CMD_REMOVE: begin
        if (held.size() > 0) begin
          e = held.pop_front();
          r.valid = 1'b1;
          r.data = e.data;
          r.key = e.key;
        end
      end
      CMD_CLEAR: begin
        held.delete();
      end
      default: ;
    endcase
    r.occ = CNT_W'(held.size());
    r.empty = (held.size() == 0);
    r.full = (held.size() >= DEPTH);
    return r;
  endfunction

  // Idle length: mostly none, sometimes short, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [KEY_WIDTH-1:0] pick_key(int kmode, int klo);
    if (kmode == 0) return KEY_WIDTH'($urandom_range(0, 255));
    if (kmode == 1) return KEY_WIDTH'(klo + int'($urandom_range(0, 3)));
    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
  endfunction

  // Queue up one random command; insert with probability ins_pct percent
  function automatic void add_random(int ins_pct, int kmode, int klo);
    cmd_row_t row;
    int       r;
    row = '0;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      row.op = CMD_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 93) row.op = CMD_REMOVE;
      else if (r < 97) row.op = CMD_CLEAR;
      else row.op = CMD_UNUSED;
    end
    row.data = DATA_WIDTH'($urandom_range(0, 65535));
    row.key = pick_key(kmode, klo);
    stim.push_back(row);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Drive commands, set the result stall, and check every accepted result
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      // result side first: its item belongs to an earlier command
      if (rsp_valid && !rsp_stall) begin
        if (pending.size() == 0) begin
          $error("result item with no command outstanding");
          errors++;
        end else begin
          want_r = pending.pop_front();
          check_field("out_data", 32'(want_r.data), 32'(out_data));
          check_field("out_key", 32'(want_r.key), 32'(out_key));
          check_field("out_valid", 32'(want_r.valid), 32'(out_valid));
          check_field("dropped", 32'(want_r.dropped), 32'(dropped));
          check_field("occupancy", 32'(want_r.occ), 32'(occupancy));
          check_field("is_empty", 32'(want_r.empty), 32'(is_empty));
          check_field("is_full", 32'(want_r.full), 32'(is_full));
        end
      end

      // command side: hold a stalled item, else accept and present the next
      if (!(cmd_valid && cmd_stall)) begin
        if (cmd_valid) begin
          got_r = queue_apply(on_bus.op, on_bus.data, on_bus.key);
          pending.push_back(on_bus.typed ? on_bus.want : got_r);
          sent++;
          cmd_gap = idle_len();
        end
        if (cmd_gap > 0) begin
          cmd_gap--;
          cmd_valid <= 1'b0;
        end else if (next_idx < stim.size()) begin
          on_bus = stim[next_idx];
          next_idx++;
          cmd_valid <= 1'b1;
          cmd <= on_bus.op;
          in_data <= on_bus.data;
          in_key <= on_bus.key;
        end else begin
          cmd_valid <= 1'b0;
        end
      end

      // result stall
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len();
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;

      if ($urandom_range(0, 63) == 0) calm = !calm;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int kmode;
    int klo;
    int n;

    // directed items; a row with typed set carries its own expectation
    directed = '{
      '{CMD_REMOVE, 16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b0, 5'd0, 1'b1, 1'b0}},
      '{CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b0, 5'd0, 1'b1, 1'b0}},
      '{CMD_CLEAR,  16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b0, 5'd0, 1'b1, 1'b0}},
      '{CMD_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b0, 5'd1, 1'b0, 1'b0}},
      '{CMD_INSERT, 16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b0, 5'd2, 1'b0, 1'b0}},
      '{CMD_REMOVE, 16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, 1'b1, 1'b0, 5'd1, 1'b0, 1'b0}},
      // fill with ties and a second largest key
      '{CMD_INSERT, 16'h0001, 8'h80, 1'b0, '0},
      '{CMD_INSERT, 16'h0002, 8'h80, 1'b0, '0},
      '{CMD_INSERT, 16'hA5A5, 8'h01, 1'b0, '0},
      '{CMD_INSERT, 16'h1234, 8'hFF, 1'b0, '0},
      '{CMD_INSERT, 16'h0003, 8'h80, 1'b0, '0},
      '{CMD_INSERT, 16'h5A5A, 8'h7F, 1'b0, '0},
      '{CMD_INSERT, 16'h0004, 8'h00, 1'b0, '0},
      '{CMD_INSERT, 16'h0005, 8'h40, 1'b0, '0},
      '{CMD_INSERT, 16'h0006, 8'h40, 1'b0, '0},
      '{CMD_INSERT, 16'h0007, 8'hC0, 1'b0, '0},
      '{CMD_INSERT, 16'h0008, 8'hC0, 1'b0, '0},
      '{CMD_INSERT, 16'h0009, 8'h02, 1'b0, '0},
      '{CMD_INSERT, 16'h000A, 8'hFE, 1'b0, '0},
      '{CMD_INSERT, 16'h000B, 8'h10, 1'b0, '0},
      '{CMD_INSERT, 16'h0BAD, 8'h20, 1'b0, '0},
      // full: key equal to the largest is dropped, a smaller one evicts the tail
      '{CMD_INSERT, 16'hDEAD, 8'hFF, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b1, 5'd16, 1'b0, 1'b1}},
      '{CMD_INSERT, 16'hBEEF, 8'h10, 1'b0, '0},
      '{CMD_UNUSED, 16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, 1'b0, 1'b0, 5'd16, 1'b0, 1'b1}},
      '{CMD_REMOVE, 16'h0000, 8'h00, 1'b0, '0}
    };
    foreach (directed[i]) stim.push_back(directed[i]);

    // random phases: fill past full, mixed traffic, drains, and noise
    while (stim.size() < DIRECTED_N + RANDOM_ITEMS) begin
      phase = $urandom_range(0, 9);
      kmode = $urandom_range(0, 2);
      klo = $urandom_range(0, 252);
      if (phase < 4) begin
        n = $urandom_range(16, 24);
        repeat (n) add_random(100, kmode, klo);
        n = $urandom_range(5, 20);
        repeat (n) add_random(80, kmode, klo);
      end else if (phase < 7) begin
        n = $urandom_range(20, 60);
        repeat (n) add_random(50, kmode, klo);
      end else if (phase < 9) begin
        n = $urandom_range(8, 20);
        repeat (n) add_random(10, kmode, klo);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) add_random(0, kmode, klo);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // drain, then wait for any stray result
    do @(negedge clk); while (!(sent == stim.size() && pending.size() == 0));
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
